@@ rtl/nnir_pkg.sv @@
// Shared types, widths and helpers of the nearest-neighbor image resize core.
// Depends on nothing; every file of the core but nnir_ram imports it.
package nnir_pkg;

  // Largest source frame the pixel store can hold
  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;

  // Field widths
  localparam int unsigned COORD_W = 8;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned PIXEL_W = 32;

  // Pixel store, row-major with a stride of MAX_WIDTH
  localparam int unsigned MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);

  // Coordinate times size stays at or below 255 * 256, so 16 bits hold the dividend
  localparam int unsigned PROD_W    = 16;
  localparam int unsigned DIV_CNT_W = $clog2(PROD_W);

  // Stream and configuration widths
  localparam int unsigned S_TDATA_W = 2 * COORD_W + PIXEL_W;
  localparam int unsigned M_TDATA_W = PIXEL_W;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_FETCH = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_DST_WIDTH  = 2'd2,
    CFG_DST_HEIGHT = 2'd3
  } cfg_idx_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic mem_write;
    logic div_start;
    logic mem_read;
    logic out_load;
  } nnir_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic coord_ok;
    logic div_last;
  } nnir_status_t;

  // Saturate a size register to 1..maxv
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

@@ rtl/nnir_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stands alone; holds the source frame of the resize core.
module nnir_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/nnir_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nnir_pkg for operand widths.
module nnir_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [nnir_pkg::PROD_W-1:0]  dividend_i,
  input  logic [nnir_pkg::SIZE_W-1:0]  divisor_i,
  output logic                         last_o,
  output logic [nnir_pkg::PROD_W-1:0]  quotient_o
);
  import nnir_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;
  logic [PROD_W-1:0]    quo_q, quo_d;
  logic [SIZE_W:0]      trial;
  logic [SIZE_W:0]      diff;
  logic                 ge;

  // One step: shift in the next dividend bit, subtract when it fits
  assign trial  = {rem_q, quo_q[PROD_W-1]};
  assign ge     = trial >= {1'b0, divisor_i};
  assign diff   = trial - {1'b0, divisor_i};
  assign last_o = busy_q && (cnt_q == DIV_CNT_W'(PROD_W - 1));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      cnt_d  = cnt_q + DIV_CNT_W'(1);
      rem_d  = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      quo_d  = {quo_q[PROD_W-2:0], ge};
      if (last_o) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;

endmodule

@@ rtl/nnir_datapath.sv @@
// Datapath of the resize core: size registers, coordinate mapping, pixel store
// and output register. Depends on nnir_pkg, nnir_div and nnir_ram.
module nnir_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  nnir_pkg::nnir_cmd_t            cmd_i,
  output nnir_pkg::nnir_status_t         status_o,
  input  logic [nnir_pkg::S_TDATA_W-1:0] in_data_i,
  input  logic                           in_mode_i,
  input  logic                           cfg_we_i,
  input  logic [nnir_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nnir_pkg::SIZE_W-1:0]    cfg_data_i,
  output logic [nnir_pkg::M_TDATA_W-1:0] pixel_out_o,
  output logic                           out_of_range_o
);
  import nnir_pkg::*;

  logic [SIZE_W-1:0]   src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [COORD_W-1:0]  in_col, in_row;
  logic [PIXEL_W-1:0]  in_pixel;
  mode_e               in_mode;
  logic [COORD_W-1:0]  col_q, row_q;
  logic                oor_q;
  logic [2*SIZE_W-1:0] prod_x, prod_y;
  logic [PROD_W-1:0]   quo_x, quo_y;
  logic [SIZE_W-1:0]   lim_x, lim_y;
  logic [COORD_W-1:0]  src_x, src_y;
  logic                last_x, last_y;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [PIXEL_W-1:0]  rdata;
  logic [PIXEL_W-1:0]  pixel_q;
  logic                oor_out_q;
  logic                coord_ok;

  // Unpack the input beat
  assign in_col   = in_data_i[COORD_W-1:0];
  assign in_row   = in_data_i[2*COORD_W-1:COORD_W];
  assign in_pixel = in_data_i[2*COORD_W+PIXEL_W-1:2*COORD_W];
  assign in_mode  = mode_e'(in_mode_i);

  // Size registers, saturated as they are written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SIZE_W'(1);
      src_h_q <= SIZE_W'(1);
      dst_w_q <= SIZE_W'(1);
      dst_h_q <= SIZE_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SRC_WIDTH:  src_w_q <= clamp_size(cfg_data_i, SIZE_W'(MAX_WIDTH));
        CFG_SRC_HEIGHT: src_h_q <= clamp_size(cfg_data_i, SIZE_W'(MAX_HEIGHT));
        CFG_DST_WIDTH:  dst_w_q <= clamp_size(cfg_data_i, SIZE_W'(MAX_WIDTH));
        CFG_DST_HEIGHT: dst_h_q <= clamp_size(cfg_data_i, SIZE_W'(MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  // Range check against the source size on load, target size on fetch
  always_comb begin
    if (in_mode == MODE_LOAD) begin
      coord_ok = ({1'b0, in_col} < src_w_q) && ({1'b0, in_row} < src_h_q);
    end else begin
      coord_ok = ({1'b0, in_col} < dst_w_q) && ({1'b0, in_row} < dst_h_q);
    end
  end

  // Capture the fetch coordinate and its range flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      col_q <= in_col;
      row_q <= in_row;
      oor_q <= (in_mode == MODE_FETCH) && !coord_ok;
    end
  end

  // Scale the coordinate; the divider loads the product into its register
  assign prod_x = {{(SIZE_W-COORD_W){1'b0}}, col_q} * src_w_q;
  assign prod_y = {{(SIZE_W-COORD_W){1'b0}}, row_q} * src_h_q;

  nnir_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_x[PROD_W-1:0]),
    .divisor_i  (dst_w_q),
    .last_o     (last_x),
    .quotient_o (quo_x)
  );

  nnir_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_y[PROD_W-1:0]),
    .divisor_i  (dst_h_q),
    .last_o     (last_y),
    .quotient_o (quo_y)
  );

  // Clamp the source coordinate to the last column and row
  assign lim_x = src_w_q - SIZE_W'(1);
  assign lim_y = src_h_q - SIZE_W'(1);
  assign src_x = (quo_x > PROD_W'(lim_x)) ? lim_x[COORD_W-1:0] : quo_x[COORD_W-1:0];
  assign src_y = (quo_y > PROD_W'(lim_y)) ? lim_y[COORD_W-1:0] : quo_y[COORD_W-1:0];

  // Row-major store addresses
  assign waddr = ADDR_W'(in_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col);
  assign raddr = ADDR_W'(src_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(src_x);

  nnir_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_write),
    .waddr_i (waddr),
    .wdata_i (in_pixel),
    .re_i    (cmd_i.mem_read),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Output register, zero pixel for an out-of-range fetch
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pixel_q   <= oor_q ? '0 : rdata;
      oor_out_q <= oor_q;
    end
  end

  assign status_o.coord_ok = coord_ok;
  assign status_o.div_last = last_x && last_y;
  assign pixel_out_o       = pixel_q;
  assign out_of_range_o    = oor_out_q;

endmodule

@@ rtl/nnir_ctrl.sv @@
// Controller of the resize core: sequences accept, divide, read and output.
// Depends on nnir_pkg for the command and status structs.
module nnir_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_mode_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output nnir_pkg::nnir_cmd_t    cmd_o,
  input  nnir_pkg::nnir_status_t status_i
);
  import nnir_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_READ,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;
  mode_e  mode;

  assign mode       = mode_e'(in_mode_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Decode commands from the state
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture   = accept;
        cmd_o.mem_write = accept && (mode == MODE_LOAD) && status_i.coord_ok;
      end
      ST_START:  cmd_o.div_start = 1'b1;
      ST_READ:   cmd_o.mem_read  = 1'b1;
      ST_FINISH: cmd_o.out_load  = out_free;
      default: ;
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && (mode == MODE_FETCH)) begin
            state_q <= status_i.coord_ok ? ST_START : ST_FINISH;
          end
        end
        ST_START: state_q <= ST_DIV;
        ST_DIV: begin
          if (status_i.div_last) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: state_q <= ST_FINISH;
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // Raise on a new result, drop once the beat is taken
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/nearest_neighbor_image_resize_core.sv @@
// Nearest-neighbor image resize core over a stored RGBA source frame.
// After a load beat the input stays open; the next beat can be accepted in the following cycle.
// An in-range fetch runs through capture, divider load, 16 divider steps, store read
// and output, and the input stays closed until its output step is done. An
// out-of-range fetch goes from capture straight to the output step with a zero result.
// The in-range path runs through the 16-step radix-2 dividers; a result that is
// still held back stalls the next fetch in its output step. Reset returns the size
// registers to one and clears control state; the pixel store keeps no reset.
module nearest_neighbor_image_resize_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // col [7:0], row [15:8], pixel_in [47:16]
  input  logic [nnir_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // mode [0]
  input  logic                           s_axis_tuser,
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pixel_out [31:0]
  output logic [nnir_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // out_of_range [0]
  output logic                           m_axis_tuser,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nnir_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nnir_pkg::SIZE_W-1:0]    cfg_data_i
);
  import nnir_pkg::*;

  nnir_cmd_t    cmd;
  nnir_status_t status;
  logic         s_accept;

  assign cfg_ready_o = 1'b1;
  assign s_accept    = s_axis_tvalid && s_axis_tready;

  nnir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_mode_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  nnir_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_data_i      (s_axis_tdata),
    .in_mode_i      (s_axis_tuser),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_out_o    (m_axis_tdata),
    .out_of_range_o (m_axis_tuser)
  );

  // An out-of-range result carries a zero pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("out-of-range result with nonzero pixel");

  // A fetch keeps the input closed in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && (s_axis_tuser == MODE_FETCH) |=> !s_axis_tready)
    else $error("input open right after a fetch");

  // A load completes in the cycle it is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && (s_axis_tuser == MODE_LOAD) |=> s_axis_tready)
    else $error("input closed after a load");

endmodule

@@ bench/tb_nearest_neighbor_image_resize_core.sv @@
// Self-checking bench for nearest_neighbor_image_resize_core: loads source pixels, fetches
// scaled pixels across many size settings and checks each result beat against a local model.
// Depends on nnir_pkg and the core RTL only.
module tb_nearest_neighbor_image_resize_core;
  import nnir_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE      = 30;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_BEATS = 160;

  typedef struct {
    mode_e               mode;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [PIXEL_W-1:0]  pix;
  } pixel_beat_t;

  typedef struct {
    logic [PIXEL_W-1:0] pix;
    logic               oor;
  } scaled_pixel_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [SIZE_W-1:0]    cfg_data_i = '0;

  // Stimulus side state
  pixel_beat_t       beat_backlog[$];
  bit                frame_loaded [MEM_DEPTH];
  logic [SIZE_W-1:0] gen_raw [4] = '{default: SIZE_W'(1)};
  bit                steady = 1'b0;
  bit                hold_arm = 1'b0;
  int unsigned       beat_total = 0;

  // Checking side state
  logic [PIXEL_W-1:0] frame_store [MEM_DEPTH];
  logic [SIZE_W-1:0]  size_regs [4] = '{default: SIZE_W'(1)};
  scaled_pixel_t      pixel_due[$];
  bit                 in_taken = 1'b0;
  int unsigned        mismatch_cnt = 0;
  int unsigned        cycle_cnt = 0;

  // Receiver hold-off bookkeeping
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;

  nearest_neighbor_image_resize_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Saturate a raw size register to 1..maxv
  function automatic int unsigned eff_size(logic [SIZE_W-1:0] raw, int unsigned maxv);
    if (raw == '0) begin
      return 1;
    end
    if (raw > maxv) begin
      return maxv;
    end
    return raw;
  endfunction

  // Nearest source index for destination index d
  function automatic int unsigned nearest_src(int unsigned d, int unsigned src,
                                              int unsigned dst);
    int unsigned s;
    s = (d * src) / dst;
    return (s > src - 1) ? src - 1 : s;
  endfunction

  // Predict the effect of one accepted beat on the store and the result stream
  task automatic resample_beat(input pixel_beat_t b);
    int unsigned   sw;
    int unsigned   sh;
    int unsigned   tw;
    int unsigned   th;
    scaled_pixel_t res;
    sw = eff_size(size_regs[CFG_SRC_WIDTH], MAX_WIDTH);
    sh = eff_size(size_regs[CFG_SRC_HEIGHT], MAX_HEIGHT);
    tw = eff_size(size_regs[CFG_DST_WIDTH], MAX_WIDTH);
    th = eff_size(size_regs[CFG_DST_HEIGHT], MAX_HEIGHT);
    if (b.mode == MODE_LOAD) begin
      if (b.col < sw && b.row < sh) begin
        frame_store[b.row * MAX_WIDTH + b.col] = b.pix;
      end
    end else begin
      if (b.col >= tw || b.row >= th) begin
        res.pix = '0;
        res.oor = 1'b1;
      end else begin
        res.pix = frame_store[nearest_src(b.row, sh, th) * MAX_WIDTH
                              + nearest_src(b.col, sw, tw)];
        res.oor = 1'b0;
      end
      pixel_due = {pixel_due, res};
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [PIXEL_W-1:0] want,
                               input logic [PIXEL_W-1:0] got);
    mismatch_cnt++;
    $display("mismatch on %s: expected %h, got %h, cycle %0d", what, want, got, cycle_cnt);
  endtask

  // Queue a load; track which store entries hold data
  task automatic push_load(input int unsigned c, input int unsigned r,
                           input logic [PIXEL_W-1:0] pix);
    pixel_beat_t b;
    b.mode = MODE_LOAD;
    b.col  = c[COORD_W-1:0];
    b.row  = r[COORD_W-1:0];
    b.pix  = pix;
    if (c < eff_size(gen_raw[CFG_SRC_WIDTH], MAX_WIDTH) &&
        r < eff_size(gen_raw[CFG_SRC_HEIGHT], MAX_HEIGHT)) begin
      frame_loaded[r * MAX_WIDTH + c] = 1'b1;
    end
    beat_backlog = {beat_backlog, b};
    beat_total++;
  endtask

  // Queue a fetch, loading its source pixel first when it was never written
  task automatic push_fetch(input int unsigned c, input int unsigned r);
    int unsigned sw;
    int unsigned sh;
    int unsigned tw;
    int unsigned th;
    int unsigned sx;
    int unsigned sy;
    pixel_beat_t b;
    sw = eff_size(gen_raw[CFG_SRC_WIDTH], MAX_WIDTH);
    sh = eff_size(gen_raw[CFG_SRC_HEIGHT], MAX_HEIGHT);
    tw = eff_size(gen_raw[CFG_DST_WIDTH], MAX_WIDTH);
    th = eff_size(gen_raw[CFG_DST_HEIGHT], MAX_HEIGHT);
    if (c < tw && r < th) begin
      sx = nearest_src(c, sw, tw);
      sy = nearest_src(r, sh, th);
      if (!frame_loaded[sy * MAX_WIDTH + sx]) begin
        push_load(sx, sy, $urandom);
      end
    end
    b.mode = MODE_FETCH;
    b.col  = c[COORD_W-1:0];
    b.row  = r[COORD_W-1:0];
    b.pix  = $urandom;
    beat_backlog = {beat_backlog, b};
    beat_total++;
  endtask

  // Write one size register over the configuration channel
  task automatic write_size(input cfg_idx_e idx, input logic [SIZE_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    gen_raw[idx] = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_sizes(input logic [SIZE_W-1:0] sw, input logic [SIZE_W-1:0] sh,
                             input logic [SIZE_W-1:0] tw, input logic [SIZE_W-1:0] th);
    write_size(CFG_SRC_WIDTH, sw);
    write_size(CFG_SRC_HEIGHT, sh);
    write_size(CFG_DST_WIDTH, tw);
    write_size(CFG_DST_HEIGHT, th);
  endtask

  // Wait until every beat is taken and every result has come, then let the core settle
  task automatic drain();
    while (beat_backlog.size() != 0 || s_axis_tvalid || pixel_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Random size, weighted toward the extremes and the saturating values
  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) begin
      return '0;
    end else if (r < 16) begin
      return SIZE_W'($urandom_range(511, 257));
    end else if (r < 30) begin
      return SIZE_W'(1);
    end else if (r < 45) begin
      return SIZE_W'(256);
    end else if (r < 65) begin
      return SIZE_W'($urandom_range(8, 2));
    end
    return SIZE_W'($urandom_range(256, 1));
  endfunction

  // Present the next pending beat; hold the current one until it is taken
  always @(negedge clk_i) begin : drive_beats
    pixel_beat_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (beat_backlog.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
        nxt = beat_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nxt.pix, nxt.row, nxt.col};
        s_axis_tuser  <= nxt.mode;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Drive result ready: one long hold-off, otherwise random stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_arm && !hold_seen) begin
      hold_seen     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 11);
    end
  end

  // Sample all handshakes: size writes, input beats, result beats
  always @(posedge clk_i) begin : watch_beats
    pixel_beat_t   b;
    scaled_pixel_t want;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        size_regs[cfg_index_i] = cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_due.size() == 0) begin
          flag_mismatch("unexpected result beat", '0, m_axis_tdata);
        end else begin
          want = pixel_due.pop_front();
          if (m_axis_tdata !== want.pix) begin
            flag_mismatch("pixel_out", want.pix, m_axis_tdata);
          end
          if (m_axis_tuser !== want.oor) begin
            flag_mismatch("out_of_range", PIXEL_W'(want.oor), PIXEL_W'(m_axis_tuser));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        b.col  = s_axis_tdata[COORD_W-1:0];
        b.row  = s_axis_tdata[2*COORD_W-1:COORD_W];
        b.pix  = s_axis_tdata[S_TDATA_W-1:2*COORD_W];
        b.mode = mode_e'(s_axis_tuser);
        resample_beat(b);
      end
    end
  end

  // Cycle budget
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_nearest_neighbor_image_resize_core failed");
      $finish;
    end
  end

  initial begin
    int unsigned roll;
    int unsigned sw;
    int unsigned sh;
    int unsigned tw;
    int unsigned th;
    int unsigned phase_base;
    bit          paused;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Reset sizes: a single pixel in, a single pixel out
    push_load(0, 0, 32'h0403_0201);
    push_fetch(0, 0);
    push_fetch(1, 0);
    push_fetch(0, 1);
    push_fetch(255, 255);
    push_load(1, 0, 32'hdead_beef);
    push_load(0, 1, 32'hffff_0000);
    drain();

    // Full frame, identity mapping, corner and middle coordinates
    write_sizes(SIZE_W'(256), SIZE_W'(256), SIZE_W'(256), SIZE_W'(256));
    push_load(255, 255, 32'hffff_ffff);
    push_fetch(255, 255);
    push_load(0, 0, 32'h0000_0000);
    push_fetch(0, 0);
    push_load(170, 85, 32'h5555_aaaa);
    push_fetch(170, 85);
    drain();

    // Saturating size values: zero acts as one, oversize acts as the maximum
    write_sizes('0, SIZE_W'(511), SIZE_W'(511), '0);
    push_fetch(255, 0);
    push_fetch(0, 1);
    push_load(1, 0, 32'h1234_5678);
    push_fetch(100, 0);
    drain();

    // Full downscale to one pixel, then an uneven upscale
    write_sizes(SIZE_W'(256), SIZE_W'(256), SIZE_W'(1), SIZE_W'(1));
    push_fetch(0, 0);
    drain();
    write_sizes(SIZE_W'(3), SIZE_W'(5), SIZE_W'(250), SIZE_W'(251));
    push_fetch(249, 250);
    push_fetch(0, 0);
    push_fetch(250, 3);
    drain();

    // Random phases: mostly in-range fetches and loads, some noise
    for (int ph = 0; ph < PHASES; ph++) begin
      steady = (ph == 3);
      if (ph == 5) begin
        hold_arm = 1'b1;
      end
      write_sizes(pick_size(), pick_size(), pick_size(), pick_size());
      sw = eff_size(gen_raw[CFG_SRC_WIDTH], MAX_WIDTH);
      sh = eff_size(gen_raw[CFG_SRC_HEIGHT], MAX_HEIGHT);
      tw = eff_size(gen_raw[CFG_DST_WIDTH], MAX_WIDTH);
      th = eff_size(gen_raw[CFG_DST_HEIGHT], MAX_HEIGHT);
      phase_base = beat_total;
      paused     = 1'b0;
      while (beat_total - phase_base < PHASE_BEATS) begin
        // In phase 7, pause the sender once mid-phase until the result stream is empty
        if (ph == 7 && !paused && beat_total - phase_base >= PHASE_BEATS / 2) begin
          drain();
          paused = 1'b1;
        end
        roll = $urandom_range(99);
        if (roll < 50) begin
          push_fetch($urandom_range(tw - 1), $urandom_range(th - 1));
        end else if (roll < 75) begin
          push_load($urandom_range(sw - 1), $urandom_range(sh - 1), $urandom);
        end else if (roll < 88) begin
          push_fetch($urandom_range(255), $urandom_range(255));
        end else begin
          push_load($urandom_range(255), $urandom_range(255), $urandom);
        end
      end
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("tb_nearest_neighbor_image_resize_core passed");
    end else begin
      $display("tb_nearest_neighbor_image_resize_core failed");
    end
    $finish;
  end

endmodule
